/* rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// All properties sample on the rising edge of aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or any sequence-based property.
`define PCSOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Next-cycle implication.
`define PCSOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pcsoc_pkg.sv */
package pcsoc_pkg;

    // Phases handled by the datapath, and ADC resolution actually used.
    localparam int PHASE_COUNT = 3;
    localparam int ADC_BITS    = 12;

    // Phases carried on the ports.
    localparam int IN_PHASES = 3;
    localparam int RAW_PH    = (PHASE_COUNT < IN_PHASES) ? PHASE_COUNT : IN_PHASES;
    localparam int PH_W      = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int RAW_W      = 12;
    localparam int CUR_W      = 16;
    localparam int CAL_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int ZC_W       = 13;
    localparam int SCALE_W    = 20;
    localparam int LIMIT_W    = 15;
    localparam int CNT_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int ACC_W      = 32;

    localparam logic [RAW_W-1:0] RAW_MASK =
        (ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);

    // Commands.
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Calibration status codes.
    localparam logic [CAL_W-1:0] CAL_IDLE = 2'd0;
    localparam logic [CAL_W-1:0] CAL_BUSY = 2'd1;
    localparam logic [CAL_W-1:0] CAL_DONE = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd4;

    // Register reset values.
    localparam logic [ZC_W-1:0]     RST_ZERO_CODE = 13'd4095;
    localparam logic [SCALE_W-1:0]  RST_SCALE     = 20'd327759;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT     = 15'd8192;
    localparam logic [CNT_W-1:0]    RST_SAMPLES   = 16'd1024;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 16'd131;

    // Controller to datapath commands.
    typedef struct packed {
        logic            accept;
        logic            mul_cur;
        logic            take_cur;
        logic            mul_off;
        logic            take_off;
        logic            load_out;
        logic [PH_W-1:0] phase;
    } dp_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_sample;
        logic cal_update;
    } dp_stat_t;

endpackage

/* rtl/pcsoc_ctrl.sv */
module pcsoc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  pcsoc_pkg::dp_stat_t dp_stat,
    output pcsoc_pkg::dp_ctl_t  dp_ctl
);
    import pcsoc_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_CUR  = 3'd1;
    localparam logic [2:0] ST_TAKE_CUR = 3'd2;
    localparam logic [2:0] ST_MUL_OFF  = 3'd3;
    localparam logic [2:0] ST_TAKE_OFF = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic            m_valid_reg, m_valid_next;
    logic            last_phase;
    logic            out_free;

    assign last_phase = (phase_reg == PH_W'(PHASE_COUNT - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        dp_ctl       = '0;
        dp_ctl.phase = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_ctl.accept = 1'b1;
                    phase_next    = '0;
                    state_next    = dp_stat.is_sample ? ST_MUL_CUR : ST_FINISH;
                end
            end
            ST_MUL_CUR: begin
                dp_ctl.mul_cur = 1'b1;
                state_next     = ST_TAKE_CUR;
            end
            ST_TAKE_CUR: begin
                dp_ctl.take_cur = 1'b1;
                if (dp_stat.cal_update) begin
                    state_next = ST_MUL_OFF;
                end else if (last_phase) begin
                    state_next = ST_FINISH;
                end else begin
                    phase_next = phase_reg + 1'b1;
                    state_next = ST_MUL_CUR;
                end
            end
            ST_MUL_OFF: begin
                dp_ctl.mul_off = 1'b1;
                state_next     = ST_TAKE_OFF;
            end
            ST_TAKE_OFF: begin
                dp_ctl.take_off = 1'b1;
                if (last_phase) begin
                    state_next = ST_FINISH;
                end else begin
                    phase_next = phase_reg + 1'b1;
                    state_next = ST_MUL_CUR;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    dp_ctl.load_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (dp_ctl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/pcsoc_datapath.sv */
module pcsoc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pcsoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcsoc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [pcsoc_pkg::CMD_W-1:0]          s_command,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_a,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_b,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_c,
    input  logic                                 s_enable_value,
    input  pcsoc_pkg::dp_ctl_t                   dp_ctl,
    output pcsoc_pkg::dp_stat_t                  dp_stat,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_a,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_b,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_c,
    output logic                                 m_overcurrent_latched,
    output logic [pcsoc_pkg::CAL_W-1:0]          m_calibration_status,
    output logic                                 m_output_enabled
);
    import pcsoc_pkg::*;

    localparam int X_W        = RAW_W + 2;
    localparam int DIFF_W     = ACC_W + 1;
    localparam int MULB_W     = SCALE_W + 1;
    localparam int PROD_W     = DIFF_W + MULB_W;
    localparam int CUR_SHIFT  = 17;
    localparam int CURRAW_W   = 18;
    localparam int Q_SHIFT    = 16;

    function automatic logic signed [CUR_W-1:0] sat16(input logic signed [CURRAW_W-1:0] v);
        logic signed [CUR_W-1:0] r;
        if (v > $signed(CURRAW_W'(32767))) begin
            r = 16'sh7FFF;
        end else if (v < -$signed(CURRAW_W'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = v[CUR_W-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [ZC_W-1:0]     zc_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]    samples_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // item and block state
    logic [RAW_W-1:0]          in_raw  [IN_PHASES];
    logic [RAW_W-1:0]          raw_reg [RAW_PH];
    logic [RAW_W-1:0]          raw_ext [PHASE_COUNT];
    logic signed [CUR_W-1:0]   last_reg [PHASE_COUNT];
    logic signed [ACC_W-1:0]   off_reg  [PHASE_COUNT];
    logic [CNT_W-1:0]          cal_count_reg;
    logic [CAL_W-1:0]          cal_phase_reg;
    logic                      oc_reg;
    logic                      enable_reg;
    logic                      cal_upd_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    // output register
    logic signed [CUR_W-1:0]   m_cur_reg [IN_PHASES];
    logic                      m_oc_reg;
    logic [CAL_W-1:0]          m_cal_reg;
    logic                      m_en_reg;

    // datapath nets
    logic [RAW_W-1:0]          raw_sel;
    logic signed [CUR_W-1:0]   last_sel;
    logic signed [ACC_W-1:0]   off_sel;
    logic signed [X_W-1:0]     x_val;
    logic signed [DIFF_W-1:0]  diff_sel;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [CURRAW_W-1:0] cur_val;
    logic signed [CURRAW_W-1:0] lim_s;
    logic                      oc_hit;
    logic signed [ACC_W-1:0]   step_val;
    logic                      cal_eligible;
    logic                      cal_below;
    logic signed [CUR_W-1:0]   cmp_ph  [PHASE_COUNT];
    logic signed [CUR_W-1:0]   cmp_out [IN_PHASES];

    assign in_raw[0] = s_raw_phase_a;
    assign in_raw[1] = s_raw_phase_b;
    assign in_raw[2] = s_raw_phase_c;

    always_comb begin
        for (int p = 0; p < PHASE_COUNT; p++) begin
            raw_ext[p] = '0;
        end
        for (int p = 0; p < RAW_PH; p++) begin
            raw_ext[p] = raw_reg[p];
        end
    end

    assign raw_sel  = raw_ext[dp_ctl.phase];
    assign last_sel = last_reg[dp_ctl.phase];
    assign off_sel  = off_reg[dp_ctl.phase];

    // 2*raw - zero code, in half LSBs
    assign x_val    = $signed({1'b0, raw_sel, 1'b0}) - $signed({1'b0, zc_reg});
    assign diff_sel = $signed({last_sel[CUR_W-1], last_sel, {Q_SHIFT{1'b0}}})
                    - $signed({off_sel[ACC_W-1], off_sel});

    // one shared multiplier: current scaling or offset smoothing
    assign mul_a = dp_ctl.mul_off ? diff_sel
                                  : $signed({{(DIFF_W - X_W){x_val[X_W-1]}}, x_val});
    assign mul_b = dp_ctl.mul_off ? $signed({{(MULB_W - WEIGHT_W){1'b0}}, weight_reg})
                                  : $signed({{(MULB_W - SCALE_W){1'b0}}, scale_reg});
    assign prod_next = mul_a * mul_b;

    assign cur_val  = prod_reg[CUR_SHIFT + CURRAW_W - 1:CUR_SHIFT];
    assign lim_s    = $signed({{(CURRAW_W - LIMIT_W){1'b0}}, limit_reg});
    assign oc_hit   = (cur_val > lim_s) || (cur_val < -lim_s);
    assign step_val = prod_reg[Q_SHIFT + ACC_W - 1:Q_SHIFT];

    assign cal_eligible = (cal_phase_reg != CAL_DONE) && !enable_reg;
    assign cal_below    = (cal_count_reg < samples_reg);

    assign dp_stat.is_sample  = (s_command == CMD_SAMPLE);
    assign dp_stat.cal_update = cal_upd_reg;

    // compensated currents from the stored state
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            d = $signed({last_reg[p][CUR_W-1], last_reg[p], {Q_SHIFT{1'b0}}})
              - $signed({off_reg[p][ACC_W-1], off_reg[p]});
            cmp_ph[p] = sat16($signed({d[DIFF_W-1], d[DIFF_W-1:Q_SHIFT]}));
        end
        for (int p = 0; p < IN_PHASES; p++) begin
            cmp_out[p] = '0;
        end
        for (int p = 0; p < RAW_PH; p++) begin
            cmp_out[p] = cmp_ph[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zc_reg      <= RST_ZERO_CODE;
            scale_reg   <= RST_SCALE;
            limit_reg   <= RST_LIMIT;
            samples_reg <= RST_SAMPLES;
            weight_reg  <= RST_WEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZERO_CODE: zc_reg      <= cfg_wdata[ZC_W-1:0];
                REG_SCALE:     scale_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_LIMIT:     limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_SAMPLES:   samples_reg <= cfg_wdata[CNT_W-1:0];
                REG_WEIGHT:    weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_ctl.accept) begin
            for (int p = 0; p < RAW_PH; p++) begin
                raw_reg[p] <= in_raw[p] & RAW_MASK;
            end
        end
        if (dp_ctl.mul_cur || dp_ctl.mul_off) begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PHASE_COUNT; p++) begin
                last_reg[p] <= '0;
                off_reg[p]  <= '0;
            end
            cal_count_reg <= '0;
            cal_phase_reg <= CAL_IDLE;
            oc_reg        <= 1'b0;
            enable_reg    <= 1'b0;
            cal_upd_reg   <= 1'b0;
        end else begin
            if (dp_ctl.accept) begin
                cal_upd_reg <= 1'b0;
                case (s_command)
                    CMD_SAMPLE: begin
                        // calibration bookkeeping depends only on the prior state
                        if (cal_eligible) begin
                            cal_upd_reg <= cal_below;
                            if (cal_below) begin
                                cal_phase_reg <= CAL_BUSY;
                                cal_count_reg <= cal_count_reg + 1'b1;
                            end else begin
                                cal_phase_reg <= CAL_DONE;
                                cal_count_reg <= '0;
                            end
                        end
                    end
                    CMD_ENABLE: enable_reg <= s_enable_value;
                    CMD_CLEAR:  oc_reg     <= 1'b0;
                    default: ;
                endcase
            end
            if (dp_ctl.take_cur) begin
                last_reg[dp_ctl.phase] <= sat16(cur_val);
                if (oc_hit) begin
                    oc_reg <= 1'b1;
                end
            end
            if (dp_ctl.take_off) begin
                off_reg[dp_ctl.phase] <= off_sel + step_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_ctl.load_out) begin
            for (int p = 0; p < IN_PHASES; p++) begin
                m_cur_reg[p] <= cmp_out[p];
            end
            m_oc_reg  <= oc_reg;
            m_cal_reg <= cal_phase_reg;
            m_en_reg  <= enable_reg;
        end
    end

    assign m_current_phase_a     = m_cur_reg[0];
    assign m_current_phase_b     = m_cur_reg[1];
    assign m_current_phase_c     = m_cur_reg[2];
    assign m_overcurrent_latched = m_oc_reg;
    assign m_calibration_status  = m_cal_reg;
    assign m_output_enabled      = m_en_reg;

endmodule

/* rtl/phase_current_sense_offset_cal.sv */
// Three-phase current sense with offset calibration. Every transaction on the s_ channel
// (sample, set output enable, clear overcurrent) returns exactly one transaction on the
// m_ channel carrying the offset-compensated phase currents (signed, 2^-10 A, saturated
// to 16 bits) and the overcurrent, calibration and enable flags as they stand after the
// command. A sample converts each ADC code as ((2*raw - zero_code_half_lsb) * amps_scale)
// >>> 17, latches overcurrent when an unsaturated current exceeds the limit in magnitude,
// and, while output is disabled and calibration is not done, smooths each phase offset.
// The phases go one after another through a single shared multiplier, each as a
// multiply and a take step, plus a second pair for the offset update while calibrating.
// s_ready is high only while the controller is idle; a finished result waits in the
// output register, so the next transaction is taken and worked on while the previous
// result is still pending, and only the final load stalls on it. Configuration
// registers (cfg_index 0 zero code, 1 scale, 2 limit, 3 calibration samples, 4
// smoothing weight) are written with cfg_wr_en; other indexes are dropped. The user
// must write them only while the block is idle; the block does not enforce this.
module phase_current_sense_offset_cal (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pcsoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcsoc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pcsoc_pkg::CMD_W-1:0]          s_command,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_a,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_b,
    input  logic [pcsoc_pkg::RAW_W-1:0]          s_raw_phase_c,
    input  logic                                 s_enable_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_a,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_b,
    output logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_c,
    output logic                                 m_overcurrent_latched,
    output logic [pcsoc_pkg::CAL_W-1:0]          m_calibration_status,
    output logic                                 m_output_enabled
);
    import pcsoc_pkg::*;

    // Controller sequences phases and the output load; datapath owns all state.
    dp_ctl_t  dp_ctl;
    dp_stat_t dp_stat;

    pcsoc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .dp_ctl  (dp_ctl)
    );

    pcsoc_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_command             (s_command),
        .s_raw_phase_a         (s_raw_phase_a),
        .s_raw_phase_b         (s_raw_phase_b),
        .s_raw_phase_c         (s_raw_phase_c),
        .s_enable_value        (s_enable_value),
        .dp_ctl                (dp_ctl),
        .dp_stat               (dp_stat),
        .m_current_phase_a     (m_current_phase_a),
        .m_current_phase_b     (m_current_phase_b),
        .m_current_phase_c     (m_current_phase_c),
        .m_overcurrent_latched (m_overcurrent_latched),
        .m_calibration_status  (m_calibration_status),
        .m_output_enabled      (m_output_enabled)
    );

endmodule

/* rtl/pcsoc_checker.sv */
`include "assert_macros.svh"

module pcsoc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [pcsoc_pkg::CMD_W-1:0]          s_command,
    input logic                                 s_enable_value,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_a,
    input logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_b,
    input logic signed [pcsoc_pkg::CUR_W-1:0]   m_current_phase_c,
    input logic                                 m_overcurrent_latched,
    input logic [pcsoc_pkg::CAL_W-1:0]          m_calibration_status,
    input logic                                 m_output_enabled
);
    import pcsoc_pkg::*;

    logic                         s_accept;
    logic                         m_stall;
    logic                         enable_go;
    logic                         clear_go;
    logic [3*CUR_W+CAL_W+1:0]     result_bits;

    assign s_accept    = s_valid && s_ready;
    assign m_stall     = m_valid && !m_ready;
    // command accepted while the output register is empty
    assign enable_go   = s_accept && (s_command == CMD_ENABLE) && !m_valid;
    assign clear_go    = s_accept && (s_command == CMD_CLEAR) && !m_valid;
    assign result_bits = {m_current_phase_a, m_current_phase_b, m_current_phase_c,
                          m_overcurrent_latched, m_calibration_status, m_output_enabled};

    // one transaction in flight: the input side closes right after an accept
    `PCSOC_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_ready, "s_ready high after accept")

    // a stalled result holds
    `PCSOC_ASSERT_NEXT(a_result_hold, m_stall, m_valid && $stable(result_bits), "stalled result changed")

    // enable command with a free output reports the new enable once the finish state loads it
    `PCSOC_ASSERT(a_enable_result, enable_go |-> ##2 (m_valid && m_output_enabled == $past(s_enable_value, 2)), "enable result wrong")

    // clear command with a free output reports a cleared flag once the finish state loads it
    `PCSOC_ASSERT(a_clear_result, clear_go |-> ##2 (m_valid && !m_overcurrent_latched), "clear result wrong")

endmodule

bind phase_current_sense_offset_cal pcsoc_checker u_pcsoc_checker (.*);
